// ===== hw/rtl/mp2a_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mp2a_pkg;

	localparam int DEF_MAX_KERNEL  = 8;
	localparam int DEF_MAX_MAP_DIM = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	// Coordinates leave the block at a fixed width.
	localparam int COORD_BITS = 10;
	localparam int ADDR_BITS  = 5;
	localparam int JOB_DEPTH  = 2;

	localparam logic [2:0] REG_KERNEL_ROWS = 3'd0;
	localparam logic [2:0] REG_KERNEL_COLS = 3'd1;
	localparam logic [2:0] REG_STRIDE_ROWS = 3'd2;
	localparam logic [2:0] REG_STRIDE_COLS = 3'd3;
	localparam logic [2:0] REG_VALID_MODE  = 3'd4;
	localparam logic [2:0] REG_MAP_ROWS    = 3'd5;
	localparam logic [2:0] REG_MAP_COLS    = 3'd6;

	typedef struct packed {
		logic [3:0]  kernel_rows;
		logic [3:0]  kernel_cols;
		logic [3:0]  stride_rows;
		logic [3:0]  stride_cols;
		logic        valid_mode;
		logic [10:0] map_rows;
		logic [10:0] map_cols;
	} cfg_t;

	// Effective window geometry handed from the front end to the scanner.
	typedef struct packed {
		logic [4:0] kr;
		logic [4:0] kc;
		logic [3:0] sr;
		logic [3:0] sc;
		logic [4:0] pt;
		logic [4:0] pl;
	} geo_t;

	function automatic int job_bits(int max_kernel, int max_map_dim, int sample_bits);
		int cw;
		int nw;
		int kw;
		int sw;
		cw = $clog2(max_map_dim);
		nw = $clog2(max_map_dim + 1) + 1;
		kw = $clog2(max_kernel + 1);
		sw = (max_kernel > 1) ? $clog2(max_kernel) : 1;
		return sample_bits + sw + 2 * cw + 1 + 2 * nw + 2 * kw;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/max_pool_2d_with_argmax.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-dimensional max pooling with argmax over one feature-map plane.
// Samples enter on the input channel (sample, in_valid, in_ready) in raster
// order, one item per sample. For each pooling window that the item closes,
// one result item leaves on the output channel with the window maximum, the
// window's output coordinates, the input coordinates of the maximum and a
// last_of_run flag on the final result caused by that sample.
// Geometry is to be programmed through the APB port only while the block
// is idle; the user must keep to this, as the block does not enforce it.
// After reset or a register write the front end works out window counts and
// padding with four serial divisions on the shared divider and four other
// steps; a geometry error skips the divisions. in_ready stays low meanwhile.
// Each item is dequeued and written to the line store; then, per window, the
// back end runs a setup step, reads each sample inside the clipped window
// in turn from the single-port line store, and ends with a last step and an
// emit step. An item that carries a geometry error goes straight to emit.
// A two-entry queue lets the front end keep taking items while the scanner
// works. When the receiver stalls, the result register holds and the
// scanner, then the queue, then in_ready back up. Reset returns the
// position to the first sample of a plane and the registers to defaults.
module max_pool_2d_with_argmax #(
	parameter int MAX_KERNEL  = mp2a_pkg::DEF_MAX_KERNEL,
	parameter int MAX_MAP_DIM = mp2a_pkg::DEF_MAX_MAP_DIM,
	parameter int SAMPLE_BITS = mp2a_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [mp2a_pkg::ADDR_BITS-1:0]      paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	output logic signed [SAMPLE_BITS-1:0]            pooled_value,
	output logic [mp2a_pkg::COORD_BITS-1:0]          out_row,
	output logic [mp2a_pkg::COORD_BITS-1:0]          out_col,
	output logic [mp2a_pkg::COORD_BITS-1:0]          arg_row,
	output logic [mp2a_pkg::COORD_BITS-1:0]          arg_col,
	output logic                                     error,
	output logic                                     last_of_run,
	output logic                                     out_valid,
	input  wire logic                                out_ready
);
	import mp2a_pkg::*;

	localparam int JW = job_bits(MAX_KERNEL, MAX_MAP_DIM, SAMPLE_BITS);

	cfg_t            cfg_q;
	logic            cfg_wr;
	logic [2:0]      reg_idx;
	geo_t            geo;
	logic [JW-1:0]   job_in;
	logic [JW-1:0]   job_out;
	logic            job_push;
	logic            job_pop;
	logic            job_full;
	logic            job_empty;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	// Register file: writes land on the access cycle of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_rows <= 4'd2;
			cfg_q.kernel_cols <= 4'd2;
			cfg_q.stride_rows <= 4'd2;
			cfg_q.stride_cols <= 4'd2;
			cfg_q.valid_mode  <= 1'b0;
			cfg_q.map_rows    <= 11'd1024;
			cfg_q.map_cols    <= 11'd1024;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_KERNEL_ROWS: cfg_q.kernel_rows <= pwdata[3:0];
				REG_KERNEL_COLS: cfg_q.kernel_cols <= pwdata[3:0];
				REG_STRIDE_ROWS: cfg_q.stride_rows <= pwdata[3:0];
				REG_STRIDE_COLS: cfg_q.stride_cols <= pwdata[3:0];
				REG_VALID_MODE:  cfg_q.valid_mode  <= pwdata[0];
				REG_MAP_ROWS:    cfg_q.map_rows    <= pwdata[10:0];
				REG_MAP_COLS:    cfg_q.map_cols    <= pwdata[10:0];
				default: begin
				end
			endcase
		end
	end

	// Read back returns the raw register contents.
	always_comb begin
		unique case (reg_idx)
			REG_KERNEL_ROWS: prdata = 32'(cfg_q.kernel_rows);
			REG_KERNEL_COLS: prdata = 32'(cfg_q.kernel_cols);
			REG_STRIDE_ROWS: prdata = 32'(cfg_q.stride_rows);
			REG_STRIDE_COLS: prdata = 32'(cfg_q.stride_cols);
			REG_VALID_MODE:  prdata = 32'(cfg_q.valid_mode);
			REG_MAP_ROWS:    prdata = 32'(cfg_q.map_rows);
			REG_MAP_COLS:    prdata = 32'(cfg_q.map_cols);
			default:         prdata = '0;
		endcase
	end

	// The front end tracks the raster position and tags each item with the
	// windows it closes.
	mp2a_front #(
		.MAX_KERNEL  (MAX_KERNEL),
		.MAX_MAP_DIM (MAX_MAP_DIM),
		.SAMPLE_BITS (SAMPLE_BITS),
		.JW          (JW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cfg_wr   (cfg_wr),
		.sample   (sample),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.job      (job_in),
		.job_push (job_push),
		.job_full (job_full),
		.geo      (geo)
	);

	mp2a_fifo #(
		.W     (JW),
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wdata  (job_in),
		.push   (job_push),
		.full   (job_full),
		.rdata  (job_out),
		.pop    (job_pop),
		.empty  (job_empty)
	);

	// The back end owns the line store, scans each closed window and holds
	// the result register.
	mp2a_back #(
		.MAX_KERNEL  (MAX_KERNEL),
		.MAX_MAP_DIM (MAX_MAP_DIM),
		.SAMPLE_BITS (SAMPLE_BITS),
		.JW          (JW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (job_out),
		.job_empty    (job_empty),
		.job_pop      (job_pop),
		.geo          (geo),
		.pooled_value (pooled_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.arg_row      (arg_row),
		.arg_col      (arg_col),
		.error        (error),
		.last_of_run  (last_of_run),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/mp2a_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mp2a_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [W-1:0] wdata,
	input  wire logic         push,
	output logic              full,
	output logic [W-1:0]      rdata,
	input  wire logic         pop,
	output logic              empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]      mem_q [DEPTH];
	logic [PW-1:0]     wp_q;
	logic [PW-1:0]     rp_q;
	logic [PW:0]       cnt_q;

	assign full  = (cnt_q == (PW + 1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW + 1)'(1);
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mp2a_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mp2a_front #(
	parameter int MAX_KERNEL  = 8,
	parameter int MAX_MAP_DIM = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int JW          = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mp2a_pkg::cfg_t         cfg,
	input  wire logic                   cfg_wr,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output logic [JW-1:0]               job,
	output logic                        job_push,
	input  wire logic                   job_full,
	output mp2a_pkg::geo_t              geo
);
	import mp2a_pkg::*;

	localparam int DW  = $clog2(MAX_MAP_DIM + 1);
	localparam int CW  = $clog2(MAX_MAP_DIM);
	localparam int NW  = DW + 1;
	localparam int EW  = DW + 2;
	localparam int XW  = NW + 6;
	localparam int KW  = $clog2(MAX_KERNEL + 1);
	localparam int SW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int TW  = $clog2(NW + 1);

	localparam logic [3:0] ST_FIX = 4'd0;
	localparam logic [3:0] ST_DR  = 4'd1;
	localparam logic [3:0] ST_DC  = 4'd2;
	localparam logic [3:0] ST_PAD = 4'd3;
	localparam logic [3:0] ST_PR  = 4'd4;
	localparam logic [3:0] ST_ER  = 4'd5;
	localparam logic [3:0] ST_PC  = 4'd6;
	localparam logic [3:0] ST_EC  = 4'd7;
	localparam logic [3:0] ST_RUN = 4'd8;

	logic [3:0]    state_q;
	logic [KW-1:0] kr_e;
	logic [KW-1:0] kc_e;
	logic [3:0]    sr_e;
	logic [3:0]    sc_e;
	logic [DW-1:0] h_e;
	logic [DW-1:0] w_e;
	logic          geo_err;

	logic [CW-1:0] pos_r_q;
	logic [CW-1:0] pos_c_q;
	logic [SW-1:0] slot_q;
	logic [NW-1:0] q_r_q;
	logic [NW-1:0] q_c_q;
	logic [KW-1:0] pt_q;
	logic [KW-1:0] pl_q;
	logic [KW-1:0] e0r_q;
	logic [KW-1:0] e0c_q;
	logic [NW-1:0] ri_q;
	logic [NW-1:0] ci_q;
	logic [EW-1:0] re_q;
	logic [EW-1:0] ce_q;

	logic          div_run_q;
	logic [TW-1:0] div_cnt_q;
	logic [NW-1:0] quo_q;
	logic [3:0]    rem_q;
	logic [NW-1:0] num_d;
	logic [3:0]    den_d;
	logic [4:0]    sh;
	logic [3:0]    rem_n;
	logic          qb;

	logic [XW-1:0] pr_w;
	logic [XW-1:0] pc_w;
	logic [KW-1:0] pt_n;
	logic [KW-1:0] pl_n;

	logic          col_last;
	logic          row_last;
	logic [NW-1:0] n_r;
	logic [NW-1:0] n_c;
	logic [NW-1:0] r_left;
	logic [NW-1:0] c_left;
	logic          r_ok;
	logic          c_ok;
	logic [KW-1:0] rm;
	logic [KW-1:0] cm;
	logic          row_hit;
	logic          accept;

	// Registers are clamped into their legal ranges before use.
	always_comb begin
		kr_e = KW'(cfg.kernel_rows);
		if (cfg.kernel_rows == '0) begin
			kr_e = KW'(1);
		end else if (32'(cfg.kernel_rows) > MAX_KERNEL) begin
			kr_e = KW'(MAX_KERNEL);
		end
		kc_e = KW'(cfg.kernel_cols);
		if (cfg.kernel_cols == '0) begin
			kc_e = KW'(1);
		end else if (32'(cfg.kernel_cols) > MAX_KERNEL) begin
			kc_e = KW'(MAX_KERNEL);
		end
		sr_e = (cfg.stride_rows == '0) ? 4'd1 : cfg.stride_rows;
		sc_e = (cfg.stride_cols == '0) ? 4'd1 : cfg.stride_cols;
		h_e = DW'(cfg.map_rows);
		if (cfg.map_rows == '0) begin
			h_e = DW'(1);
		end else if (32'(cfg.map_rows) > MAX_MAP_DIM) begin
			h_e = DW'(MAX_MAP_DIM);
		end
		w_e = DW'(cfg.map_cols);
		if (cfg.map_cols == '0) begin
			w_e = DW'(1);
		end else if (32'(cfg.map_cols) > MAX_MAP_DIM) begin
			w_e = DW'(MAX_MAP_DIM);
		end
		geo_err = cfg.valid_mode && ((32'(kr_e) > 32'(h_e)) || (32'(kc_e) > 32'(w_e)));
	end

	// Dividend and divisor of the shared restoring divider.
	always_comb begin
		num_d = '0;
		den_d = sc_e;
		case (state_q)
			ST_DR: begin
				den_d = sr_e;
				num_d = cfg.valid_mode ? NW'(h_e) - NW'(kr_e) : NW'(h_e) - NW'(1);
			end
			ST_DC: begin
				num_d = cfg.valid_mode ? NW'(w_e) - NW'(kc_e) : NW'(w_e) - NW'(1);
			end
			ST_PR: begin
				den_d = sr_e;
				if (XW'(pos_r_q) > XW'(e0r_q)) begin
					num_d = NW'(XW'(pos_r_q) - XW'(e0r_q) + XW'(sr_e) - XW'(1));
				end
			end
			ST_PC: begin
				if (XW'(pos_c_q) > XW'(e0c_q)) begin
					num_d = NW'(XW'(pos_c_q) - XW'(e0c_q) + XW'(sc_e) - XW'(1));
				end
			end
			default: begin
				num_d = '0;
			end
		endcase
		sh = {rem_q, quo_q[NW-1]};
		if (sh >= {1'b0, den_d}) begin
			rem_n = 4'(sh - {1'b0, den_d});
			qb    = 1'b1;
		end else begin
			rem_n = sh[3:0];
			qb    = 1'b0;
		end
	end

	// Total padding is negative-clamped and halved for the top and left side; valid mode has none.
	always_comb begin
		pr_w = XW'(q_r_q) * XW'(sr_e) + XW'(kr_e) - XW'(h_e);
		pc_w = XW'(q_c_q) * XW'(sc_e) + XW'(kc_e) - XW'(w_e);
		pt_n = (cfg.valid_mode || pr_w[XW-1]) ? '0 : KW'(pr_w >> 1);
		pl_n = (cfg.valid_mode || pc_w[XW-1]) ? '0 : KW'(pc_w >> 1);
	end

	// Which windows end at this position. Only the last row or column can
	// close several windows at once, since clipping merges their ends.
	always_comb begin
		col_last = (DW'(pos_c_q) == w_e - DW'(1));
		row_last = (DW'(pos_r_q) == h_e - DW'(1));
		n_r      = q_r_q + NW'(1);
		n_c      = q_c_q + NW'(1);
		r_ok     = ri_q < n_r;
		c_ok     = ci_q < n_c;
		r_left   = n_r - ri_q;
		c_left   = n_c - ci_q;
		row_hit  = r_ok && (re_q == EW'(pos_r_q));
		if (row_last) begin
			rm = !r_ok ? '0 : ((32'(r_left) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(r_left));
		end else begin
			rm = row_hit ? KW'(1) : '0;
		end
		if (col_last) begin
			cm = !c_ok ? '0 : ((32'(c_left) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(c_left));
		end else begin
			cm = (c_ok && (ce_q == EW'(pos_c_q))) ? KW'(1) : '0;
		end
	end

	assign in_ready = (state_q == ST_RUN) && !job_full;
	assign accept   = in_valid && in_ready;
	assign job_push = accept;
	assign job      = {sample, slot_q, pos_r_q, pos_c_q, geo_err, ri_q, rm, ci_q, cm};

	assign geo.kr = 5'(kr_e);
	assign geo.kc = 5'(kc_e);
	assign geo.sr = sr_e;
	assign geo.sc = sc_e;
	assign geo.pt = 5'(pt_q);
	assign geo.pl = 5'(pl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FIX;
			pos_r_q   <= '0;
			pos_c_q   <= '0;
			slot_q    <= '0;
			div_run_q <= 1'b0;
			div_cnt_q <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			q_r_q     <= '0;
			q_c_q     <= '0;
			pt_q      <= '0;
			pl_q      <= '0;
			e0r_q     <= '0;
			e0c_q     <= '0;
			ri_q      <= '0;
			ci_q      <= '0;
			re_q      <= '0;
			ce_q      <= '0;
		end else if (cfg_wr) begin
			state_q   <= ST_FIX;
			div_run_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_FIX: begin
					if ((32'(pos_r_q) >= 32'(h_e)) || (32'(pos_c_q) >= 32'(w_e))) begin
						pos_r_q <= '0;
						pos_c_q <= '0;
						slot_q  <= '0;
					end
					state_q <= geo_err ? ST_RUN : ST_DR;
				end
				ST_DR, ST_DC, ST_PR, ST_PC: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
						div_cnt_q <= TW'(NW);
						quo_q     <= num_d;
						rem_q     <= '0;
					end else if (div_cnt_q == '0) begin
						div_run_q <= 1'b0;
						unique case (state_q)
							ST_DR: begin
								q_r_q   <= quo_q;
								state_q <= ST_DC;
							end
							ST_DC: begin
								q_c_q   <= quo_q;
								state_q <= ST_PAD;
							end
							ST_PR: begin
								ri_q    <= quo_q;
								state_q <= ST_ER;
							end
							default: begin
								ci_q    <= quo_q;
								state_q <= ST_EC;
							end
						endcase
					end else begin
						div_cnt_q <= div_cnt_q - TW'(1);
						quo_q     <= {quo_q[NW-2:0], qb};
						rem_q     <= rem_n;
					end
				end
				ST_PAD: begin
					pt_q    <= pt_n;
					pl_q    <= pl_n;
					e0r_q   <= kr_e - KW'(1) - pt_n;
					e0c_q   <= kc_e - KW'(1) - pl_n;
					state_q <= ST_PR;
				end
				ST_ER: begin
					re_q    <= EW'(e0r_q) + EW'(sr_e) * EW'(ri_q);
					state_q <= ST_PC;
				end
				ST_EC: begin
					ce_q    <= EW'(e0c_q) + EW'(sc_e) * EW'(ci_q);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (accept) begin
						if (col_last) begin
							pos_c_q <= '0;
							ci_q    <= '0;
							ce_q    <= EW'(e0c_q);
							if (row_last) begin
								pos_r_q <= '0;
								slot_q  <= '0;
								ri_q    <= '0;
								re_q    <= EW'(e0r_q);
							end else begin
								pos_r_q <= pos_r_q + CW'(1);
								slot_q  <= (slot_q == SW'(MAX_KERNEL - 1)) ? '0 : slot_q + SW'(1);
								if (row_hit) begin
									ri_q <= ri_q + NW'(1);
									re_q <= re_q + EW'(sr_e);
								end
							end
						end else begin
							pos_c_q <= pos_c_q + CW'(1);
							if (cm != '0) begin
								ci_q <= ci_q + NW'(1);
								ce_q <= ce_q + EW'(sc_e);
							end
						end
					end
				end
				default: begin
					state_q <= ST_FIX;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/mp2a_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mp2a_back #(
	parameter int MAX_KERNEL  = 8,
	parameter int MAX_MAP_DIM = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int JW          = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [JW-1:0]                       job,
	input  wire logic                                job_empty,
	output logic                                     job_pop,
	input  wire mp2a_pkg::geo_t                      geo,
	output logic signed [SAMPLE_BITS-1:0]            pooled_value,
	output logic [mp2a_pkg::COORD_BITS-1:0]          out_row,
	output logic [mp2a_pkg::COORD_BITS-1:0]          out_col,
	output logic [mp2a_pkg::COORD_BITS-1:0]          arg_row,
	output logic [mp2a_pkg::COORD_BITS-1:0]          arg_col,
	output logic                                     error,
	output logic                                     last_of_run,
	output logic                                     out_valid,
	input  wire logic                                out_ready
);
	import mp2a_pkg::*;

	localparam int DW    = $clog2(MAX_MAP_DIM + 1);
	localparam int CW    = $clog2(MAX_MAP_DIM);
	localparam int NW    = DW + 1;
	localparam int SXW   = NW + 6;
	localparam int KW    = $clog2(MAX_KERNEL + 1);
	localparam int SW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int DEPTH = MAX_KERNEL * MAX_MAP_DIM;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_SETUP = 3'd1;
	localparam logic [2:0] B_SCAN  = 3'd2;
	localparam logic [2:0] B_LAST  = 3'd3;
	localparam logic [2:0] B_EMIT  = 3'd4;

	logic [SAMPLE_BITS-1:0] j_sample;
	logic [SW-1:0]          j_slot;
	logic [CW-1:0]          j_row;
	logic [CW-1:0]          j_col;
	logic                   j_err;
	logic [NW-1:0]          j_ri0;
	logic [KW-1:0]          j_rm;
	logic [NW-1:0]          j_ci0;
	logic [KW-1:0]          j_cm;

	logic [SAMPLE_BITS-1:0] store_q [DEPTH];
	logic [2:0]             state_q;
	logic [SW-1:0]          slot_r_q;
	logic [CW-1:0]          row_q;
	logic [CW-1:0]          col_q;
	logic                   err_q;
	logic [NW-1:0]          ri0_q;
	logic [KW-1:0]          rm_q;
	logic [NW-1:0]          ci0_q;
	logic [KW-1:0]          cm_q;
	logic [KW-1:0]          a_q;
	logic [KW-1:0]          b_q;

	logic [CW-1:0]          y_q;
	logic [CW-1:0]          x_q;
	logic [CW-1:0]          ye_q;
	logic [CW-1:0]          xs_q;
	logic [CW-1:0]          xe_q;
	logic [SW-1:0]          ys_q;

	logic                   rd_v_s1;
	logic [SAMPLE_BITS-1:0] rdata_s1;
	logic [CW-1:0]          y_s1;
	logic [CW-1:0]          x_s1;
	logic                   found_q;
	logic [SAMPLE_BITS-1:0] best_q;
	logic [CW-1:0]          br_q;
	logic [CW-1:0]          bc_q;

	logic [NW-1:0]          wri;
	logic [NW-1:0]          wci;
	logic signed [SXW-1:0]  rs_u;
	logic signed [SXW-1:0]  cs_u;
	logic [SXW-1:0]         re_u;
	logic [SXW-1:0]         ce_u;
	logic [CW-1:0]          rs;
	logic [CW-1:0]          cs;
	logic [CW-1:0]          diff;
	logic [SW:0]            slot_t;
	logic [SW-1:0]          slot_y;
	logic [AW-1:0]          waddr;
	logic [AW-1:0]          raddr;
	logic                   out_free;
	logic                   win_last;

	assign {j_sample, j_slot, j_row, j_col, j_err, j_ri0, j_rm, j_ci0, j_cm} = job;

	assign job_pop  = (state_q == B_IDLE) && !job_empty;
	assign waddr    = AW'(j_slot) * AW'(MAX_MAP_DIM) + AW'(j_col);
	assign raddr    = AW'(ys_q) * AW'(MAX_MAP_DIM) + AW'(x_q);
	assign out_free = !out_valid || out_ready;
	assign win_last = err_q || ((a_q == rm_q - KW'(1)) && (b_q == cm_q - KW'(1)));

	// Window bounds, clipped to the map and to the current position.
	always_comb begin
		wri  = ri0_q + NW'(a_q);
		wci  = ci0_q + NW'(b_q);
		rs_u = SXW'(geo.sr) * SXW'(wri) - SXW'(geo.pt);
		cs_u = SXW'(geo.sc) * SXW'(wci) - SXW'(geo.pl);
		re_u = rs_u + SXW'(geo.kr) - SXW'(1);
		ce_u = cs_u + SXW'(geo.kc) - SXW'(1);
		rs   = rs_u[SXW-1] ? '0 : CW'(rs_u);
		cs   = cs_u[SXW-1] ? '0 : CW'(cs_u);
		diff = row_q - rs;
		slot_t = (SW + 1)'(slot_r_q) + (SW + 1)'(MAX_KERNEL) - (SW + 1)'(diff);
		if (slot_t >= (SW + 1)'(MAX_KERNEL)) begin
			slot_y = SW'(slot_t - (SW + 1)'(MAX_KERNEL));
		end else begin
			slot_y = SW'(slot_t);
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			store_q[waddr] <= j_sample;
		end
		rdata_s1 <= store_q[raddr];
		y_s1     <= y_q;
		x_s1     <= x_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			rd_v_s1     <= 1'b0;
			out_valid   <= 1'b0;
			found_q     <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			slot_r_q    <= '0;
			row_q       <= '0;
			col_q       <= '0;
			err_q       <= 1'b0;
			ri0_q       <= '0;
			rm_q        <= '0;
			ci0_q       <= '0;
			cm_q        <= '0;
			y_q         <= '0;
			x_q         <= '0;
			ye_q        <= '0;
			xs_q        <= '0;
			xe_q        <= '0;
			ys_q        <= '0;
			best_q      <= '0;
			br_q        <= '0;
			bc_q        <= '0;
			pooled_value <= '0;
			out_row     <= '0;
			out_col     <= '0;
			arg_row     <= '0;
			arg_col     <= '0;
			error       <= 1'b0;
			last_of_run <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == B_SCAN);
			if (rd_v_s1 && (!found_q || ($signed(rdata_s1) > $signed(best_q)))) begin
				found_q <= 1'b1;
				best_q  <= rdata_s1;
				br_q    <= y_s1;
				bc_q    <= x_s1;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						slot_r_q <= j_slot;
						row_q    <= j_row;
						col_q    <= j_col;
						err_q    <= j_err;
						ri0_q    <= j_ri0;
						rm_q     <= j_rm;
						ci0_q    <= j_ci0;
						cm_q     <= j_cm;
						a_q      <= '0;
						b_q      <= '0;
						if (j_err) begin
							state_q <= B_EMIT;
						end else if ((j_rm != '0) && (j_cm != '0)) begin
							state_q <= B_SETUP;
						end
					end
				end
				B_SETUP: begin
					found_q <= 1'b0;
					y_q     <= rs;
					x_q     <= cs;
					xs_q    <= cs;
					ys_q    <= slot_y;
					ye_q    <= (re_u > SXW'(row_q)) ? row_q : CW'(re_u);
					xe_q    <= (ce_u > SXW'(col_q)) ? col_q : CW'(ce_u);
					state_q <= B_SCAN;
				end
				B_SCAN: begin
					if (x_q == xe_q) begin
						x_q <= xs_q;
						if (y_q == ye_q) begin
							state_q <= B_LAST;
						end else begin
							y_q  <= y_q + CW'(1);
							ys_q <= (ys_q == SW'(MAX_KERNEL - 1)) ? '0 : ys_q + SW'(1);
						end
					end else begin
						x_q <= x_q + CW'(1);
					end
				end
				B_LAST: begin
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						error       <= err_q;
						last_of_run <= win_last;
						if (err_q) begin
							pooled_value <= '0;
							out_row      <= '0;
							out_col      <= '0;
							arg_row      <= '0;
							arg_col      <= '0;
						end else begin
							pooled_value <= best_q;
							out_row      <= COORD_BITS'(wri);
							out_col      <= COORD_BITS'(wci);
							arg_row      <= COORD_BITS'(br_q);
							arg_col      <= COORD_BITS'(bc_q);
						end
						if (win_last) begin
							state_q <= B_IDLE;
						end else begin
							state_q <= B_SETUP;
							if (b_q == cm_q - KW'(1)) begin
								b_q <= '0;
								a_q <= a_q + KW'(1);
							end else begin
								b_q <= b_q + KW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
